[hdl/ucit_pkg.sv]
// Shared types and constants for the used column interval tracker.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package ucit_pkg;

  // Fixed geometry that the port fields settle.
  localparam int unsigned BLOCKS     = 16;
  localparam int unsigned BLOCK_COLS = 4096;
  localparam int unsigned RUNS_DEF   = 16;
  localparam int unsigned GAP_RESET  = 32;

  // Field widths.
  localparam int unsigned BLKW  = 4;
  localparam int unsigned COLW  = 12;
  localparam int unsigned LENW  = 13;
  localparam int unsigned GAPW  = 13;
  localparam int unsigned SUMW  = 14;
  localparam int unsigned IDXW  = 4;
  localparam int unsigned CNTOW = 5;

  // Request kinds.
  localparam logic OP_MARK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Configuration register addresses.
  localparam logic [1:0] ADDR_GAP = 2'd0;

  // One stored run.
  typedef struct packed {
    logic [COLW-1:0] first;
    logic [LENW-1:0] len;
  } run_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]        status;
    logic [BLOCKS-1:0] mask;
    logic [CNTOW-1:0]  cnt;
    logic [LENW-1:0]   len;
    logic [COLW-1:0]   first;
    logic [IDXW-1:0]   idx;
  } result_t;

endpackage
`default_nettype wire

[hdl/ucit_run_mem.sv]
// Run storage: one simple dual-port memory with a registered read port.
// Depends on ucit_pkg for the run entry type.
`default_nettype none
module ucit_run_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire                  clk_i,
  input  wire                  we_i,
  input  wire  [AW-1:0]        waddr_i,
  input  ucit_pkg::run_t       wdata_i,
  input  wire  [AW-1:0]        raddr_i,
  output ucit_pkg::run_t       rdata_o
);

  ucit_pkg::run_t mem_q [DEPTH];
  ucit_pkg::run_t rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hdl/ucit_ctrl.sv]
// Request sequencer: scans, inserts, merges and compacts runs in the run memory,
// keeps run counts and the block mask, and holds the result register.
// Depends on ucit_pkg and drives ucit_run_mem.
`default_nettype none
module ucit_ctrl #(
  parameter int unsigned RUNS_PER_BLOCK = ucit_pkg::RUNS_DEF,
  parameter int unsigned AW             = 8
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire  [ucit_pkg::GAPW-1:0]      gap_i,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire                            in_op_i,
  input  wire  [ucit_pkg::BLKW-1:0]      in_blk_i,
  input  wire  [ucit_pkg::COLW-1:0]      in_col_i,
  input  wire  [ucit_pkg::LENW-1:0]      in_w_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output ucit_pkg::result_t              out_o,
  output logic                           mem_we_o,
  output logic [AW-1:0]                  mem_waddr_o,
  output ucit_pkg::run_t                 mem_wdata_o,
  output logic [AW-1:0]                  mem_raddr_o,
  input  ucit_pkg::run_t                 mem_rdata_i
);

  localparam int unsigned CNTW = $clog2(RUNS_PER_BLOCK + 1);
  localparam int unsigned NB   = ucit_pkg::BLOCKS;
  localparam int unsigned SW   = ucit_pkg::SUMW;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_CMP, S_INS_CHK, S_SH_RD, S_SH_WR,
    S_ABS_RD, S_ABS_CMP, S_FIN, S_CMP_RD, S_CMP_WR, S_DONE
  } state_e;

  state_e                    state_q;
  logic                      op_q;
  logic [ucit_pkg::BLKW-1:0] blk_q;
  logic [ucit_pkg::COLW-1:0] col_q;
  logic [ucit_pkg::LENW-1:0] w_q;
  logic [ucit_pkg::GAPW-1:0] gap_q;
  logic [CNTW-1:0]           n_q, idx_q, j_q, k_q, d_q;
  logic [ucit_pkg::COLW-1:0] cur_b_q;
  logic [ucit_pkg::LENW-1:0] cur_s_q;
  logic [CNTW-1:0]           total_q [NB];
  logic [NB-1:0]             mask_q;
  ucit_pkg::result_t         res_q, out_q;
  logic                      out_valid_q;

  logic [SW-1:0]   rd_end, rd_reach, cur_end, req_end, merge_end;
  logic [NB-1:0]   mask_new;
  logic [ucit_pkg::COLW-1:0] merge_b;

  function automatic logic [AW-1:0] addr_of(input logic [ucit_pkg::BLKW-1:0] blk,
                                            input logic [CNTW-1:0] idx);
    int unsigned a;
    a = int'(blk) * RUNS_PER_BLOCK + int'(idx);
    return a[AW-1:0];
  endfunction

  function automatic logic [ucit_pkg::IDXW-1:0] idx_out(input logic [CNTW-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[ucit_pkg::IDXW-1:0];
  endfunction

  function automatic logic [ucit_pkg::CNTOW-1:0] cnt_out(input logic [CNTW-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[ucit_pkg::CNTOW-1:0];
  endfunction

  // Sums used by the scan, merge and absorb compares, the merged run start and the updated block mask.
  always_comb begin
    rd_end   = SW'(mem_rdata_i.first) + SW'(mem_rdata_i.len);
    rd_reach = rd_end;
    cur_end  = SW'(cur_b_q) + SW'(cur_s_q);
    req_end  = SW'(col_q) + SW'(w_q);
    merge_end = (req_end > rd_end) ? req_end : rd_end;
    merge_b   = (col_q < mem_rdata_i.first) ? col_q : mem_rdata_i.first;
    mask_new  = mask_q | (NB'(1) << blk_q);
  end

  // Memory port control per state.
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = addr_of(blk_q, idx_q);
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = addr_of(blk_q, idx_q);
    case (state_q)
      S_SH_RD: begin
        mem_raddr_o = addr_of(blk_q, k_q - CNTW'(1));
        if (k_q == idx_q) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = '{first: col_q, len: w_q};
        end
      end
      S_SH_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = addr_of(blk_q, k_q);
      end
      S_ABS_RD: mem_raddr_o = addr_of(blk_q, j_q);
      S_FIN: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = '{first: cur_b_q, len: cur_s_q};
      end
      S_CMP_RD: mem_raddr_o = addr_of(blk_q, k_q);
      S_CMP_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = addr_of(blk_q, k_q - d_q);
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Sequencer, counts, mask and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mask_q      <= '0;
      for (int i = 0; i < NB; i++) begin
        total_q[i] <= '0;
      end
    end else begin
      // A taken result frees the output register unless a new one loads now.
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= in_op_i;
            blk_q   <= in_blk_i;
            col_q   <= in_col_i;
            w_q     <= in_w_i;
            gap_q   <= gap_i;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          n_q   <= total_q[blk_q];
          idx_q <= '0;
          if (op_q == ucit_pkg::OP_CLEAR) begin
            res_q   <= '0;
            mask_q  <= '0;
            state_q <= S_DONE;
            for (int i = 0; i < NB; i++) begin
              total_q[i] <= '0;
            end
          end else if (32'(blk_q) >= NB) begin
            res_q   <= '{status: ucit_pkg::ST_RANGE, mask: mask_q, default: '0};
            state_q <= S_DONE;
          end else if (w_q == '0 || req_end > SW'(ucit_pkg::BLOCK_COLS)) begin
            res_q   <= '{status: ucit_pkg::ST_RANGE, mask: mask_q,
                         cnt: cnt_out(total_q[blk_q]), default: '0};
            state_q <= S_DONE;
          end else begin
            state_q <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state_q <= (idx_q == n_q) ? S_INS_CHK : S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (rd_end + SW'(gap_q) < SW'(col_q)) begin
            idx_q   <= idx_q + CNTW'(1);
            state_q <= S_SCAN_RD;
          end else if (req_end + SW'(gap_q) < SW'(mem_rdata_i.first)) begin
            state_q <= S_INS_CHK;
          end else begin
            cur_b_q <= merge_b;
            cur_s_q <= ucit_pkg::LENW'(merge_end - SW'(merge_b));
            j_q     <= idx_q + CNTW'(1);
            state_q <= S_ABS_RD;
          end
        end
        S_INS_CHK: begin
          if (32'(n_q) >= RUNS_PER_BLOCK) begin
            res_q   <= '{status: ucit_pkg::ST_FULL, mask: mask_q,
                         cnt: cnt_out(n_q), default: '0};
            state_q <= S_DONE;
          end else begin
            k_q     <= n_q;
            state_q <= S_SH_RD;
          end
        end
        S_SH_RD: begin
          if (k_q == idx_q) begin
            total_q[blk_q] <= n_q + CNTW'(1);
            mask_q         <= mask_new;
            res_q          <= '{status: ucit_pkg::ST_OK, mask: mask_new,
                                cnt: cnt_out(n_q + CNTW'(1)), len: w_q,
                                first: col_q, idx: idx_out(idx_q)};
            state_q        <= S_DONE;
          end else begin
            state_q <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          k_q     <= k_q - CNTW'(1);
          state_q <= S_SH_RD;
        end
        S_ABS_RD: state_q <= (j_q == n_q) ? S_FIN : S_ABS_CMP;
        S_ABS_CMP: begin
          if (cur_end + SW'(gap_q) >= SW'(mem_rdata_i.first)) begin
            if (rd_reach > cur_end) begin
              cur_s_q <= ucit_pkg::LENW'(rd_reach - SW'(cur_b_q));
            end
            j_q     <= j_q + CNTW'(1);
            state_q <= S_ABS_RD;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          d_q     <= j_q - idx_q - CNTW'(1);
          k_q     <= j_q;
          state_q <= S_CMP_RD;
        end
        S_CMP_RD: begin
          if (k_q == n_q) begin
            total_q[blk_q] <= n_q - d_q;
            mask_q         <= mask_new;
            res_q          <= '{status: ucit_pkg::ST_OK, mask: mask_new,
                                cnt: cnt_out(n_q - d_q), len: cur_s_q,
                                first: cur_b_q, idx: idx_out(idx_q)};
            state_q        <= S_DONE;
          end else begin
            state_q <= S_CMP_WR;
          end
        end
        S_CMP_WR: begin
          k_q     <= k_q + CNTW'(1);
          state_q <= S_CMP_RD;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/used_column_interval_tracker.sv]
// Top level of the used column interval tracker: stream ports, APB register,
// run memory and request sequencer. Depends on ucit_pkg, ucit_run_mem, ucit_ctrl.
//
// Usage: each input transaction is a mark request (tuser = 0) naming a block,
// a start column and a width, or a clear request (tuser = 1). Every request
// yields exactly one result transaction with the covering run, the block's
// run count, the block mask and a status code.
// A clear request, or one with a bad block or range, goes from the check
// straight to its result; a full block is found after the scan. A mark
// request reads each run it scans, shifts on insert, absorbs or moves down
// on compaction, through the run memory's registered read port; every later
// run is handled once. One request is in work at a time; the next is taken
// as soon as the sequencer is idle, even while the previous result waits in
// the output register. Reset clears the block mask and all run counts at
// once and loads merge_gap with 32; run memory contents need no clearing.
// When the receiver stalls, the result holds in the output register and the
// block finishes at most one further request before it waits. merge_gap is
// to be written only while the block is idle; the user is bound to this and
// the block itself does not enforce it.
`default_nettype none
module used_column_interval_tracker #(
  parameter int unsigned RUNS_PER_BLOCK = ucit_pkg::RUNS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: block_id[3:0], start_col[15:4], width[28:16], zero fill[31:29]
  input  wire  [31:0] s_axis_tdata,
  // tuser: op[0]
  input  wire  [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata: run_index[3:0], run_start[15:4], run_length[28:16],
  // runs_in_block[33:29], blocks_in_use[49:34], status[51:50], zero fill[55:52]
  output logic [55:0] m_axis_tdata,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [1:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DEPTH = ucit_pkg::BLOCKS * RUNS_PER_BLOCK;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [ucit_pkg::GAPW-1:0] gap_q;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  ucit_pkg::run_t            mem_wdata, mem_rdata;
  ucit_pkg::result_t         res;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= ucit_pkg::GAPW'(ucit_pkg::GAP_RESET);
    end else if (psel && penable && pwrite && paddr == ucit_pkg::ADDR_GAP) begin
      gap_q <= pwdata[ucit_pkg::GAPW-1:0];
    end
  end
  assign prdata = (paddr == ucit_pkg::ADDR_GAP) ? 32'(gap_q) : '0;

  ucit_run_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ucit_ctrl #(.RUNS_PER_BLOCK(RUNS_PER_BLOCK), .AW(AW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gap_i       (gap_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser[0]),
    .in_blk_i    (s_axis_tdata[3:0]),
    .in_col_i    (s_axis_tdata[15:4]),
    .in_w_i      (s_axis_tdata[28:16]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Output packing; the spare high bits of tdata are zero fill.
  assign m_axis_tdata = {4'b0000, res};

endmodule
`default_nettype wire

[hdl/ucit_checker.sv]
// Port-level checks for the used column interval tracker, bound to the top level.
// Depends on ucit_pkg and used_column_interval_tracker.
`default_nettype none
module ucit_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [55:0] m_axis_tdata
);

  // A waiting result stays offered until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // Only one request is in work: the input closes right after a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a request is in work");

  // Status is one of the three defined codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[51:50] != 2'd3)
    else $error("undefined status code");

  // A rejected request reports no covering run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[51:50] != ucit_pkg::ST_OK |->
      m_axis_tdata[28:0] == 29'd0)
    else $error("rejected request reports a run");

  // A successful mark (nonzero run count) reports a nonempty block mask and run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[51:50] == ucit_pkg::ST_OK &&
      m_axis_tdata[33:29] != 5'd0 |->
      m_axis_tdata[49:34] != 16'd0 && m_axis_tdata[28:16] != 13'd0)
    else $error("marked block missing from mask or empty run");

endmodule

bind used_column_interval_tracker ucit_checker u_ucit_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
